// ===== hdl/rps_pkg.sv =====
// Package for the random permutation shuffler: beat structs, codes and
// generator constants. No dependencies.
`timescale 1ns / 1ps

package rps_pkg;

    localparam int DEF_MAX_ELEMENTS = 128;
    localparam int DEF_VALUE_WIDTH  = 16;

    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 7;
    localparam int ELEMENT_W   = 16;
    localparam int COUNT_W     = 8;
    localparam int SEED_W      = 64;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd114;

    localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;
    localparam int SM_SHIFT1 = 30;
    localparam int SM_SHIFT2 = 27;
    localparam int SM_SHIFT3 = 31;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [INDEX_W-1:0]   index;
        logic [ELEMENT_W-1:0] element_value;
    } item_t;

    typedef struct packed {
        logic [ELEMENT_W-1:0] read_value;
        logic                 index_error;
    } result_t;

endpackage

// ===== hdl/random_permutation_shuffler.sv =====
// Random permutation shuffler: element table, splitmix64 draws and in-place
// Fisher-Yates pass over one shared 32x32 multiplier. Uses rps_pkg.
// Load, error and unused-mode beats answer straight from ST_IDLE, reads via ST_READ_OUT;
// a shuffle at used count n does n-1 swaps, each through MIX, MUL, SCALE, FETCH, WR_TOP, WR_PART.
// Loads run back to back; busy blocks beats during reads and shuffles. No output stall.
// Reset clears control, count_in_use to 114 and generator state; table not cleared.
`timescale 1ns / 1ps

module random_permutation_shuffler #(
    parameter int MAX_ELEMENTS = rps_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_WIDTH  = rps_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rps_pkg::item_t                    item,
    output logic                              result_valid,
    output rps_pkg::result_t                  result,
    input  logic                              cfg_write,
    input  logic [rps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = ($clog2(MAX_ELEMENTS + 1) > rps_pkg::COUNT_W)
                            ? $clog2(MAX_ELEMENTS + 1) : rps_pkg::COUNT_W;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_READ_OUT = 8'b0000_0010,
        ST_MIX      = 8'b0000_0100,
        ST_MUL      = 8'b0000_1000,
        ST_SCALE    = 8'b0001_0000,
        ST_FETCH    = 8'b0010_0000,
        ST_WR_TOP   = 8'b0100_0000,
        ST_WR_PART  = 8'b1000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [1:0]                    phase_reg, phase_next;
    logic                          round_reg, round_next;
    logic [63:0]                   gen_reg, gen_next;
    logic [rps_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [63:0]                   z_reg, z_next;
    logic [63:0]                   acc_reg, acc_next;
    logic [63:0]                   prod_reg, prod_next;
    logic [ADDR_W-1:0]             top_reg, top_next;
    logic [ADDR_W-1:0]             part_reg, part_next;
    rps_pkg::result_t              result_reg, result_next;
    logic                          result_valid_reg, result_valid_next;
    logic [VALUE_WIDTH-1:0]        rd_a_reg, rd_b_reg;

    logic [VALUE_WIDTH-1:0]        mem [MAX_ELEMENTS];

    logic [CNT_W-1:0]              count_ext;
    logic [CNT_W-1:0]              used_cnt;
    logic [CNT_W-1:0]              idx_ext;
    logic [CNT_W-1:0]              top_start;
    logic [ADDR_W-1:0]             item_addr;
    logic                          idx_bad;
    logic [63:0]                   mix_sum;
    logic [63:0]                   mul_const;
    logic [31:0]                   scale_n;
    logic [31:0]                   mul_a, mul_b;
    logic [63:0]                   sum_mul;
    logic [63:0]                   mid;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [VALUE_WIDTH-1:0]        mem_wdata;
    logic [ADDR_W-1:0]             raddr_a;
    logic                          rd_en;

    assign count_ext = CNT_W'(count_reg);
    assign used_cnt  = (count_ext > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count_ext;
    assign idx_ext   = CNT_W'(item.index);
    assign idx_bad   = (idx_ext >= used_cnt);
    assign item_addr = idx_ext[ADDR_W-1:0];
    assign top_start = used_cnt - CNT_W'(1);

    assign mix_sum   = gen_reg + rps_pkg::SM_GAMMA;
    assign mul_const = round_reg ? rps_pkg::SM_MUL2 : rps_pkg::SM_MUL1;
    assign scale_n   = 32'(top_reg) + 32'd1;
    assign sum_mul   = acc_reg + {prod_reg[31:0], 32'd0};
    assign mid       = prod_reg + {32'd0, acc_reg[63:32]};
    assign prod_next = 64'(mul_a) * 64'(mul_b);

    assign raddr_a = (state_reg == ST_IDLE) ? item_addr : top_reg;
    assign rd_en   = (state_reg == ST_IDLE) || (state_reg == ST_FETCH);

    always_comb
    begin
        mul_a = z_reg[31:0];
        mul_b = mul_const[31:0];
        unique case (state_reg)
            ST_MUL:
            begin
                if (phase_reg == 2'd1)
                begin
                    mul_b = mul_const[63:32];
                end
                else if (phase_reg == 2'd2)
                begin
                    mul_a = z_reg[63:32];
                end
            end
            ST_SCALE:
            begin
                mul_b = scale_n;
                if (phase_reg == 2'd1)
                begin
                    mul_a = z_reg[63:32];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        round_next        = round_reg;
        gen_next          = gen_reg;
        count_next        = count_reg;
        z_next            = z_reg;
        acc_next          = acc_reg;
        top_next          = top_reg;
        part_next         = part_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = top_reg;
        mem_wdata         = rd_b_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next = '0;
                    unique case (item.mode)
                        rps_pkg::MODE_LOAD:
                        begin
                            result_valid_next       = 1'b1;
                            result_next.index_error = idx_bad;
                            if (!idx_bad)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = item_addr;
                                mem_wdata = VALUE_WIDTH'(item.element_value);
                            end
                        end
                        rps_pkg::MODE_READ:
                        begin
                            if (idx_bad)
                            begin
                                result_valid_next       = 1'b1;
                                result_next.index_error = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_READ_OUT;
                            end
                        end
                        rps_pkg::MODE_SHUFFLE:
                        begin
                            if (used_cnt < CNT_W'(2))
                            begin
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                top_next   = top_start[ADDR_W-1:0];
                                state_next = ST_MIX;
                            end
                        end
                        default:
                        begin
                            result_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_OUT:
            begin
                result_next.read_value  = rps_pkg::ELEMENT_W'(rd_a_reg);
                result_next.index_error = 1'b0;
                result_valid_next       = 1'b1;
                state_next              = ST_IDLE;
            end
            ST_MIX:
            begin
                gen_next   = mix_sum;
                z_next     = mix_sum ^ (mix_sum >> rps_pkg::SM_SHIFT1);
                phase_next = 2'd0;
                round_next = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                phase_next = phase_reg + 2'd1;
                unique case (phase_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    2'd2:
                    begin
                        acc_next = sum_mul;
                    end
                    default:
                    begin
                        phase_next = 2'd0;
                        if (!round_reg)
                        begin
                            z_next     = sum_mul ^ (sum_mul >> rps_pkg::SM_SHIFT2);
                            round_next = 1'b1;
                        end
                        else
                        begin
                            z_next     = sum_mul ^ (sum_mul >> rps_pkg::SM_SHIFT3);
                            state_next = ST_SCALE;
                        end
                    end
                endcase
            end
            ST_SCALE:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd1)
                begin
                    acc_next = prod_reg;
                end
                else if (phase_reg == 2'd2)
                begin
                    part_next  = mid[32 +: ADDR_W];
                    phase_next = 2'd0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_WR_TOP;
            end
            ST_WR_TOP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = top_reg;
                mem_wdata  = rd_b_reg;
                state_next = ST_WR_PART;
            end
            ST_WR_PART:
            begin
                mem_we    = 1'b1;
                mem_waddr = part_reg;
                mem_wdata = rd_a_reg;
                if (top_reg == ADDR_W'(1))
                begin
                    result_next       = '0;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    top_next   = top_reg - ADDR_W'(1);
                    state_next = ST_MIX;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            if (cfg_index == rps_pkg::CFG_SEED)
            begin
                gen_next = cfg_data;
            end
            else if (cfg_index == rps_pkg::CFG_COUNT)
            begin
                count_next = cfg_data[rps_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= 2'd0;
            round_reg        <= 1'b0;
            gen_reg          <= '0;
            count_reg        <= rps_pkg::COUNT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            round_reg        <= round_next;
            gen_reg          <= gen_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg      <= z_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        top_reg    <= top_next;
        part_reg   <= part_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[part_reg];
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> result_valid || busy)
        else $error("accepted beat neither answered nor started");

    a_done_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result");

    a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !result_valid || $fell(busy) || $past(state_reg) == ST_IDLE)
        else $error("result shown in the middle of a pass");

    a_partner_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> part_reg <= top_reg)
        else $error("swap partner above top index");
`endif

endmodule

// ===== test/random_permutation_shuffler_tb.sv =====
// Self-checking testbench for random_permutation_shuffler: directed and random
// load, read and shuffle beats, each result compared with an in-bench model.
// Depends on rps_pkg and the shuffler RTL.
`timescale 1ns / 1ps

module random_permutation_shuffler_tb;

    localparam logic [rps_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = rps_pkg::DEF_MAX_ELEMENTS;
    localparam int PHASES = 12;
    localparam int PHASE_BEATS = 62;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rps_pkg::item_t item = '0;
    logic result_valid;
    rps_pkg::result_t result;
    logic cfg_write = 1'b0;
    logic [rps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    rps_pkg::item_t pending_beats[$];
    rps_pkg::result_t expected_results[$];
    logic item_taken = 1'b0;
    logic calm = 1'b0;
    int mismatch_count = 0;

    logic [rps_pkg::ELEMENT_W-1:0] model_table [TABLE_DEPTH];
    logic [rps_pkg::SEED_W-1:0] draw_state = '0;
    logic [rps_pkg::COUNT_W-1:0] model_count = rps_pkg::COUNT_RESET;

    random_permutation_shuffler dut (
        .clk,
        .rst_n,
        .start,
        .busy,
        .item,
        .result_valid,
        .result,
        .cfg_write,
        .cfg_index,
        .cfg_data
    );

    always #2 clk = ~clk;

    function automatic int unsigned used_count(logic [rps_pkg::COUNT_W-1:0] count);
        return (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    endfunction

    function automatic rps_pkg::result_t expected_outcome(rps_pkg::item_t beat);
        rps_pkg::result_t outcome;
        int unsigned used;
        int unsigned partner;
        logic [63:0] z;
        logic [127:0] product;
        logic [rps_pkg::ELEMENT_W-1:0] held;
        outcome = '0;
        used = used_count(model_count);
        case (beat.mode)
            rps_pkg::MODE_LOAD, rps_pkg::MODE_READ:
            begin
                if (beat.index >= used)
                    outcome.index_error = 1'b1;
                else if (beat.mode == rps_pkg::MODE_LOAD)
                    model_table[beat.index] = beat.element_value;
                else
                    outcome.read_value = model_table[beat.index];
            end
            rps_pkg::MODE_SHUFFLE:
            begin
                for (int i = int'(used); i > 1; i--)
                begin
                    draw_state = draw_state + rps_pkg::SM_GAMMA;
                    z = draw_state;
                    z = (z ^ (z >> rps_pkg::SM_SHIFT1)) * rps_pkg::SM_MUL1;
                    z = (z ^ (z >> rps_pkg::SM_SHIFT2)) * rps_pkg::SM_MUL2;
                    z = z ^ (z >> rps_pkg::SM_SHIFT3);
                    product = 128'(z) * 128'(i);
                    partner = 32'(product[127:64]);
                    held = model_table[i - 1];
                    model_table[i - 1] = model_table[partner];
                    model_table[partner] = held;
                end
            end
            default:
            begin
            end
        endcase
        return outcome;
    endfunction

    function automatic void queue_beat(logic [rps_pkg::MODE_W-1:0] mode,
                                       logic [rps_pkg::INDEX_W-1:0] index,
                                       logic [rps_pkg::ELEMENT_W-1:0] value);
        rps_pkg::item_t beat;
        beat.mode = mode;
        beat.index = index;
        beat.element_value = value;
        pending_beats.push_back(beat);
    endfunction

    function automatic void queue_random_beat(int unsigned used);
        rps_pkg::item_t beat;
        int unsigned pick;
        int unsigned shuffle_pct;
        shuffle_pct = (used > 64) ? 3 : 15;
        pick = $urandom_range(99);
        beat.element_value = rps_pkg::ELEMENT_W'($urandom_range(16'hFFFF));
        if (used == 0 || $urandom_range(9) == 0)
            beat.index = rps_pkg::INDEX_W'($urandom_range(TABLE_DEPTH - 1));
        else
            beat.index = rps_pkg::INDEX_W'($urandom_range(used - 1));
        if (pick < shuffle_pct)
            beat.mode = rps_pkg::MODE_SHUFFLE;
        else if (pick < shuffle_pct + 3)
            beat.mode = MODE_UNUSED;
        else if (pick < 45)
            beat.mode = rps_pkg::MODE_LOAD;
        else
            beat.mode = rps_pkg::MODE_READ;
        pending_beats.push_back(beat);
    endfunction

    task automatic write_reg(logic [rps_pkg::CFG_INDEX_W-1:0] index,
                             logic [rps_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_beats.size() != 0 || start || busy || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // hold the current beat until taken, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n && (!start || item_taken))
        begin
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 9))
            begin
                item <= pending_beats.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        rps_pkg::result_t want;
        if (result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result beat: read_value %h index_error %b",
                             result.read_value, result.index_error);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.read_value !== want.read_value ||
                    result.index_error !== want.index_error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected read_value %h index_error %b, %s %h %s %b",
                                 want.read_value, want.index_error, "got read_value",
                                 result.read_value, "index_error", result.index_error);
                end
            end
        end
        if (cfg_write)
        begin
            if (cfg_index == rps_pkg::CFG_SEED)
                draw_state = cfg_data;
            else
                model_count = cfg_data[rps_pkg::COUNT_W-1:0];
        end
        if (start && !busy)
            expected_results.push_back(expected_outcome(item));
        item_taken <= start && !busy;
    end

    initial
    begin : stimulus
        logic [rps_pkg::COUNT_W-1:0] count_plan [PHASES];
        logic [rps_pkg::CFG_DATA_W-1:0] reg_value;
        int unsigned used;
        count_plan = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd5, 8'd129,
                       8'd128, 8'd17, 8'd2, 8'd64, 8'd3, 8'd11};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_beat(rps_pkg::MODE_LOAD, 7'd0, 16'h0000);
        queue_beat(rps_pkg::MODE_LOAD, 7'd113, 16'hFFFF);
        queue_beat(rps_pkg::MODE_LOAD, 7'd57, 16'hA5A5);
        queue_beat(rps_pkg::MODE_LOAD, 7'd114, 16'h1234);
        queue_beat(rps_pkg::MODE_LOAD, 7'd127, 16'hFFFF);
        queue_beat(rps_pkg::MODE_READ, 7'd0, 16'hFFFF);
        queue_beat(rps_pkg::MODE_READ, 7'd113, 16'h0000);
        queue_beat(rps_pkg::MODE_READ, 7'd57, 16'h5A5A);
        queue_beat(rps_pkg::MODE_READ, 7'd114, 16'h0000);
        queue_beat(rps_pkg::MODE_READ, 7'd127, 16'hFFFF);
        queue_beat(MODE_UNUSED, 7'd127, 16'hFFFF);
        queue_beat(MODE_UNUSED, 7'd0, 16'h0000);
        queue_beat(rps_pkg::MODE_SHUFFLE, 7'd85, 16'h5A5A);
        queue_beat(rps_pkg::MODE_LOAD, 7'd0, 16'h5A5A);
        queue_beat(rps_pkg::MODE_READ, 7'd0, 16'h0000);
        wait_idle();

        // fill the whole table so every later read hits a written entry
        write_reg(rps_pkg::CFG_SEED, '1);
        reg_value = {$urandom(), $urandom()};
        reg_value[rps_pkg::COUNT_W-1:0] = 8'd128;
        write_reg(rps_pkg::CFG_COUNT, reg_value);
        calm = 1'b1;
        @(posedge clk);
        for (int k = 0; k < TABLE_DEPTH; k++)
            queue_beat(rps_pkg::MODE_LOAD, rps_pkg::INDEX_W'(k),
                       rps_pkg::ELEMENT_W'($urandom_range(16'hFFFF)));
        repeat (40) queue_random_beat(TABLE_DEPTH);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == 6);
            if (p % 3 != 2)
            begin
                case ($urandom_range(3))
                    0: reg_value = '0;
                    1: reg_value = '1;
                    default: reg_value = {$urandom(), $urandom()};
                endcase
                write_reg(rps_pkg::CFG_SEED, reg_value);
            end
            reg_value = {$urandom(), $urandom()};
            reg_value[rps_pkg::COUNT_W-1:0] = count_plan[p];
            write_reg(rps_pkg::CFG_COUNT, reg_value);
            used = used_count(count_plan[p]);
            @(posedge clk);
            repeat (PHASE_BEATS) queue_random_beat(used);
            wait_idle();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("random_permutation_shuffler_tb passed");
        else
            $display("random_permutation_shuffler_tb failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("random_permutation_shuffler_tb failed");
        $finish;
    end

endmodule
